>>> hdl/vec3_arithmetic_unit_defines.svh
// assertion macros for the vector unit checker
// used by vau_checker.sv, expects clk and rst in scope
`ifndef VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define VAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/vau_pkg.sv
// shared types, constants and helper functions of the vector unit
// no dependencies
package vau_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 2 * WORD_BITS + 2;
  localparam int NEAR_LO       = 999;
  localparam int NEAR_HI       = 1001;
  localparam int NEAR_DEN      = 1000;
  localparam int NEAR_BITS     = 10;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_ADDS  = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_DIVS  = 4'd4,
    CMD_DOT   = 4'd5,
    CMD_CROSS = 4'd6,
    CMD_NORM  = 4'd7,
    CMD_NORMZ = 4'd8
  } cmd_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [DW-1:0]        wide_t;

  localparam wide_t SAT_MAX = {{(DW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam wide_t SAT_MIN = {{(DW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    logic [3:0] cmd;
    vec_t       a;
    vec_t       b;
    word_t      s;
  } item_t;

  typedef struct packed {
    word_t val;
    logic  ovf;
  } sat_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t sc;
    logic  ovf;
    logic  dz;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic [3:0]           cmd;
    vec_t                 a;
    logic                 s_neg;
    logic [WORD_BITS-1:0] s_mag;
    res_t                 res;
  } ctx_t;

  typedef struct packed {
    logic valid;
    logic div_en;
    res_t res;
  } dctx_t;

  function automatic sat_t sat_wide(wide_t v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[WORD_BITS-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[WORD_BITS-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // arithmetic shift right, truncating toward zero
  function automatic wide_t rescale(wide_t v, int unsigned f);
    wide_t bias;
    bias = v[DW-1] ? ((wide_t'(1) <<< f) - wide_t'(1)) : '0;
    return (v + bias) >>> f;
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(word_t v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

>>> hdl/vau_lane.sv
// one component lane: multipliers, adder, rescale and saturation
// depends on vau_pkg
module vau_lane import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       adv,
  input  logic [3:0] cmd,
  input  word_t      a,
  input  word_t      b,
  input  word_t      s,
  input  word_t      ca0,
  input  word_t      cb0,
  input  word_t      ca1,
  input  word_t      cb1,
  output wide_t      prod,
  output sat_t       res
);

  logic [3:0]                    cmd1;
  word_t                         m0a;
  word_t                         m0b;
  logic signed [2*WORD_BITS-1:0] p0;
  logic signed [2*WORD_BITS-1:0] p1;
  logic signed [WORD_BITS:0]     sum_in;
  logic signed [WORD_BITS:0]     sum1;
  wide_t                         pre;

  always_comb begin
    m0a = a;
    m0b = b;
    case (cmd)
      CMD_SCALE: m0b = s;
      CMD_CROSS: begin
        m0a = ca0;
        m0b = cb0;
      end
      CMD_NORM, CMD_NORMZ: m0b = a;
      default: ;
    endcase
  end

  always_comb begin
    case (cmd)
      CMD_SUB:  sum_in = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      CMD_ADDS: sum_in = {a[WORD_BITS-1], a} + {s[WORD_BITS-1], s};
      default:  sum_in = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= cmd;
      p0   <= (2*WORD_BITS)'(m0a) * (2*WORD_BITS)'(m0b);
      p1   <= (2*WORD_BITS)'(ca1) * (2*WORD_BITS)'(cb1);
      sum1 <= sum_in;
    end
  end

  always_comb begin
    case (cmd1)
      CMD_ADD, CMD_SUB, CMD_ADDS: pre = DW'(sum1);
      CMD_SCALE:                  pre = rescale(DW'(p0), FRAC_BITS);
      CMD_CROSS:                  pre = rescale(DW'(p0) - DW'(p1), FRAC_BITS);
      default:                    pre = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= sat_wide(pre);
    end
  end

  assign prod = DW'(p0);

endmodule

>>> hdl/vau_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on vau_pkg
module vau_sqrt import vau_pkg::*; (
  input  logic                   clk,
  input  logic                   adv,
  input  logic [2*WORD_BITS-1:0] x,
  output logic [WORD_BITS-1:0]   root
);

  localparam int NS = WORD_BITS;
  localparam int RB = WORD_BITS + 1;

  logic [RB-1:0]          rem_q  [NS];
  logic [WORD_BITS-1:0]   root_q [NS];
  logic [2*WORD_BITS-1:0] xr_q   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RB-1:0]          rem_p;
    logic [WORD_BITS-1:0]   root_p;
    logic [2*WORD_BITS-1:0] xr_p;
    logic [RB+1:0]          rem_sh;
    logic [RB+1:0]          trial;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign xr_p   = x;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign xr_p   = xr_q[k-1];
    end

    assign rem_sh = {rem_p, xr_p[2*WORD_BITS-1 -: 2]};
    assign trial  = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= RB'(rem_sh - trial);
          root_q[k] <= {root_p[WORD_BITS-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh[RB-1:0];
          root_q[k] <= {root_p[WORD_BITS-2:0], 1'b0};
        end
        xr_q[k] <= xr_p << 2;
      end
    end
  end

  assign root = root_q[NS-1];

endmodule

>>> hdl/vau_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on vau_pkg
module vau_div import vau_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int QW        = WORD_BITS + FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  input  logic                 neg,
  output logic [QW-1:0]        q,
  output logic                 q_neg
);

  logic [WORD_BITS-1:0] rem_q [QW];
  logic [QW-1:0]        quo_q [QW];
  logic [QW-1:0]        nr_q  [QW];
  logic [WORD_BITS-1:0] den_q [QW];
  logic                 neg_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [WORD_BITS-1:0] rem_p;
    logic [QW-1:0]        quo_p;
    logic [QW-1:0]        nr_p;
    logic [WORD_BITS-1:0] den_p;
    logic                 neg_p;
    logic [WORD_BITS:0]   t;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign quo_p = '0;
      assign nr_p  = {num, {FRAC_BITS{1'b0}}};
      assign den_p = den;
      assign neg_p = neg;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign quo_p = quo_q[k-1];
      assign nr_p  = nr_q[k-1];
      assign den_p = den_q[k-1];
      assign neg_p = neg_q[k-1];
    end

    assign t  = {rem_p, nr_p[QW-1]};
    assign ge = t >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= ge ? WORD_BITS'(t - {1'b0, den_p}) : t[WORD_BITS-1:0];
        quo_q[k] <= {quo_p[QW-2:0], ge};
        nr_q[k]  <= nr_p << 1;
        den_q[k] <= den_p;
        neg_q[k] <= neg_p;
      end
    end
  end

  assign q     = quo_q[QW-1];
  assign q_neg = neg_q[QW-1];

endmodule

>>> hdl/vec3_arithmetic_unit.sv
// data is Q16.16 at the default FRAC_BITS
// throughput: one transaction per cycle while req_stall is low; all commands share one fixed-depth pipeline
// depth is set by the input and lane registers, the square root stages, the divisor register and the divider stages
// req_stall rises only when the two-entry result buffer is full
// reset clears stage valid bits and the result buffer; no clearing pass
module vec3_arithmetic_unit import vau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [3:0] cmd,
  input  word_t      a_x,
  input  word_t      a_y,
  input  word_t      a_z,
  input  word_t      b_x,
  input  word_t      b_y,
  input  word_t      b_z,
  input  word_t      scalar_in,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output word_t      r_x,
  output word_t      r_y,
  output word_t      r_z,
  output word_t      r_scalar,
  output logic       overflow,
  output logic       div_zero
);

  localparam int QW = WORD_BITS + FRAC_BITS;
  localparam int NT = WORD_BITS + NEAR_BITS;
  localparam logic [NT-1:0]        NEAR_LO_Q = NT'(NEAR_LO) << FRAC_BITS;
  localparam logic [NT-1:0]        NEAR_HI_Q = NT'(NEAR_HI) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] NORM_MAX  = SAT_MAX[WORD_BITS-1:0];

  logic                 adv;
  logic                 v0, v1, v2;
  item_t                it0, it1, it2;
  wide_t                l_prod [3];
  sat_t                 l_res  [3];
  wide_t                sum2;
  ctx_t                 c_in;
  ctx_t                 c [WORD_BITS];
  sat_t                 dot_s;
  logic [WORD_BITS-1:0] root;
  ctx_t                 cs;
  logic [NT-1:0]        near_t;
  dctx_t                m_in;
  dctx_t                m_ctx;
  logic [WORD_BITS-1:0] den_in;
  logic                 dsign;
  logic [WORD_BITS-1:0] m_den;
  logic [WORD_BITS-1:0] m_num [3];
  logic                 m_neg [3];
  dctx_t                d [QW];
  logic [QW-1:0]        q     [3];
  logic                 q_neg [3];
  wide_t                qw    [3];
  sat_t                 qs    [3];
  dctx_t                ds;
  res_t                 fin;
  res_t                 ob [2];
  logic [1:0]           cnt;
  logic                 push, pop;
  logic                 wr_idx;

  assign adv       = cnt != 2'd2;
  assign req_stall = !adv;

  // lanes, with the cross product operand pairs per component
  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .adv(adv), .cmd(it0.cmd), .a(it0.a.x), .b(it0.b.x), .s(it0.s),
    .ca0(it0.a.y), .cb0(it0.b.z), .ca1(it0.a.z), .cb1(it0.b.y),
    .prod(l_prod[0]), .res(l_res[0])
  );

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .adv(adv), .cmd(it0.cmd), .a(it0.a.y), .b(it0.b.y), .s(it0.s),
    .ca0(it0.a.z), .cb0(it0.b.x), .ca1(it0.a.x), .cb1(it0.b.z),
    .prod(l_prod[1]), .res(l_res[1])
  );

  vau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .adv(adv), .cmd(it0.cmd), .a(it0.a.z), .b(it0.b.z), .s(it0.s),
    .ca0(it0.a.x), .cb0(it0.b.y), .ca1(it0.a.y), .cb1(it0.b.x),
    .prod(l_prod[2]), .res(l_res[2])
  );

  // merge of the lanes: dot product and early results
  always_comb begin
    dot_s          = sat_wide(rescale(sum2, FRAC_BITS));
    c_in.valid     = v2;
    c_in.cmd       = it2.cmd;
    c_in.a         = it2.a;
    c_in.s_neg     = it2.s[WORD_BITS-1];
    c_in.s_mag     = mag(it2.s);
    c_in.res.x     = l_res[0].val;
    c_in.res.y     = l_res[1].val;
    c_in.res.z     = l_res[2].val;
    c_in.res.sc    = '0;
    c_in.res.ovf   = l_res[0].ovf | l_res[1].ovf | l_res[2].ovf;
    c_in.res.dz    = 1'b0;
    if (it2.cmd == CMD_DOT) begin
      c_in.res.sc  = dot_s.val;
      c_in.res.ovf = dot_s.ovf;
    end
  end

  vau_sqrt u_sqrt (
    .clk(clk), .adv(adv), .x(sum2[2*WORD_BITS-1:0]), .root(root)
  );

  // norm result, near-unit test and divisor choice
  always_comb begin
    cs          = c[WORD_BITS-1];
    near_t      = NT'(root) * NT'(NEAR_DEN);
    m_in.valid  = cs.valid;
    m_in.div_en = 1'b0;
    m_in.res    = cs.res;
    den_in      = cs.s_mag;
    dsign       = cs.s_neg;
    case (cs.cmd)
      CMD_DIVS: begin
        if (cs.s_mag == '0) begin
          m_in.res.dz = 1'b1;
        end else begin
          m_in.div_en = 1'b1;
        end
      end
      CMD_NORM: begin
        if (root > NORM_MAX) begin
          m_in.res.sc  = word_t'(NORM_MAX);
          m_in.res.ovf = 1'b1;
        end else begin
          m_in.res.sc  = word_t'(root);
        end
      end
      CMD_NORMZ: begin
        den_in = root;
        dsign  = 1'b0;
        if (near_t >= NEAR_LO_Q && near_t <= NEAR_HI_Q) begin
          m_in.res.x = cs.a.x;
          m_in.res.y = cs.a.y;
          m_in.res.z = cs.a.z;
        end else if (root == '0) begin
          m_in.res.dz = 1'b1;
        end else begin
          m_in.div_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .adv(adv), .num(m_num[0]), .den(m_den), .neg(m_neg[0]),
    .q(q[0]), .q_neg(q_neg[0])
  );

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .adv(adv), .num(m_num[1]), .den(m_den), .neg(m_neg[1]),
    .q(q[1]), .q_neg(q_neg[1])
  );

  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk(clk), .adv(adv), .num(m_num[2]), .den(m_den), .neg(m_neg[2]),
    .q(q[2]), .q_neg(q_neg[2])
  );

  always_comb begin
    ds = d[QW-1];
    for (int i = 0; i < 3; i++) begin
      qw[i] = DW'(q[i]);
      qs[i] = sat_wide(q_neg[i] ? -qw[i] : qw[i]);
    end
    fin = ds.res;
    if (ds.div_en) begin
      fin.x   = qs[0].val;
      fin.y   = qs[1].val;
      fin.z   = qs[2].val;
      fin.ovf = ds.res.ovf | qs[0].ovf | qs[1].ovf | qs[2].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      m_ctx.valid <= 1'b0;
      for (int k = 0; k < WORD_BITS; k++) begin
        c[k].valid <= 1'b0;
      end
      for (int k = 0; k < QW; k++) begin
        d[k].valid <= 1'b0;
      end
    end else if (adv) begin
      v0  <= req_valid;
      it0 <= '{cmd: cmd, a: '{x: a_x, y: a_y, z: a_z}, b: '{x: b_x, y: b_y, z: b_z},
               s: scalar_in};
      v1   <= v0;
      it1  <= it0;
      v2   <= v1;
      it2  <= it1;
      sum2 <= l_prod[0] + l_prod[1] + l_prod[2];
      c[0] <= c_in;
      for (int k = 1; k < WORD_BITS; k++) begin
        c[k] <= c[k-1];
      end
      m_ctx    <= m_in;
      m_den    <= den_in;
      m_num[0] <= mag(cs.a.x);
      m_num[1] <= mag(cs.a.y);
      m_num[2] <= mag(cs.a.z);
      m_neg[0] <= cs.a.x[WORD_BITS-1] ^ dsign;
      m_neg[1] <= cs.a.y[WORD_BITS-1] ^ dsign;
      m_neg[2] <= cs.a.z[WORD_BITS-1] ^ dsign;
      d[0]     <= m_ctx;
      for (int k = 1; k < QW; k++) begin
        d[k] <= d[k-1];
      end
    end
  end

  // two-entry result buffer
  assign push   = adv && ds.valid;
  assign pop    = rsp_valid && !rsp_stall;
  assign wr_idx = (cnt == 2'd1) && !pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push && !wr_idx) begin
      ob[0] <= fin;
    end else if (pop) begin
      ob[0] <= ob[1];
    end
    if (push && wr_idx) begin
      ob[1] <= fin;
    end
  end

  assign rsp_valid = cnt != 2'd0;
  assign r_x       = ob[0].x;
  assign r_y       = ob[0].y;
  assign r_z       = ob[0].z;
  assign r_scalar  = ob[0].sc;
  assign overflow  = ob[0].ovf;
  assign div_zero  = ob[0].dz;

endmodule

>>> hdl/vau_checker.sv
// port-level checks of the vector unit, bound to the top level
// depends on vau_pkg and vec3_arithmetic_unit_defines.svh
`include "vec3_arithmetic_unit_defines.svh"

module vau_checker import vau_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input word_t      r_x,
  input word_t      r_y,
  input word_t      r_z,
  input word_t      r_scalar,
  input logic       overflow,
  input logic       div_zero
);

  `VAU_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(r_scalar) && $stable(overflow) && $stable(div_zero), "stalled transaction dropped or changed")
  `VAU_ASSERT_IMP(a_stall_cause, req_stall, $past(rsp_valid && rsp_stall), "input stalled without a stalled result")
  `VAU_ASSERT_IMP(a_dz_zero, rsp_valid && div_zero, r_x == 0 && r_y == 0 && r_z == 0 && r_scalar == 0 && !overflow, "divide by zero result not cleared")
  `VAU_ASSERT_IMP(a_scalar_only, rsp_valid && r_scalar != 0, r_x == 0 && r_y == 0 && r_z == 0 && !div_zero, "scalar and vector result both set")

endmodule

bind vec3_arithmetic_unit vau_checker u_vau_checker (.*);
